>>> hdl/idea_pkg.sv
// ----------------------------------------------------------------------------
// IDEA datapath package
// Shared constants and the modulo 2^16+1 reduction used by the round stages.
// ----------------------------------------------------------------------------
package idea_pkg;

   localparam int unsigned RoundsDefault = 8;
   localparam int unsigned WordW        = 16;
   localparam int unsigned BlockW       = 64;
   localparam int unsigned KeyIdxW      = 6;
   localparam int unsigned KeysPerRound = 6;
   localparam int unsigned OutKeys      = 4;

   localparam logic CmdLoad  = 1'b0;
   localparam logic CmdBlock = 1'b1;

   typedef logic [WordW-1:0] word_type;

   // Reduce a 33-bit product of two 17-bit operands (zero stands for 2^16)
   // modulo 2^16+1: hi/lo split, subtract, fold.
   function automatic word_type mul_reduce(input logic [32:0] p);
      logic [15:0] lo;
      logic [16:0] hi;
      logic [17:0] d;
      begin
         lo = p[15:0];
         hi = p[32:16];
         if ({1'b0, lo} >= hi) begin
            d = {1'b0, lo} - {1'b0, hi};
         end else begin
            d = {2'b0, lo} + 18'd65537 - {1'b0, hi};
         end
         mul_reduce = d[15:0];
      end
   endfunction

   function automatic logic [16:0] mul_ext(input word_type w);
      mul_ext = (w == '0) ? 17'h10000 : {1'b0, w};
   endfunction

endpackage

>>> hdl/idea_round.sv
// ----------------------------------------------------------------------------
// IDEA round
// One cipher round as four register stages with a shared stall enable.
// ----------------------------------------------------------------------------
module idea_round
   import idea_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [BlockW-1:0]   in_block,
   input  word_type            k0,
   input  word_type            k1,
   input  word_type            k2,
   input  word_type            k3,
   input  word_type            k4,
   input  word_type            k5,
   output logic                out_valid,
   output logic [BlockW-1:0]   out_block
);

   logic [3:0] v_ff;
   logic [3:0] v_in;

   // stage 1: products and sums
   logic [32:0] pa_ff, pd_ff, pa_in, pd_in;
   word_type    b1_ff, c1_ff, b1_in, c1_in;
   // stage 2: reduce, e*k4 product
   word_type    a2_ff, b2_ff, c2_ff, d2_ff, f2_ff;
   logic [32:0] pe_ff;
   // stage 3: ek reduce, (f+ek)*k5 product
   word_type    a3_ff, b3_ff, c3_ff, d3_ff, ek3_ff;
   logic [32:0] pt_ff;
   // stage 4: output
   logic [BlockW-1:0] out_ff, out_in;

   word_type a2_in, d2_in, e2, ek3_in, t4, u4;

   assign pa_in = 33'(mul_ext(in_block[63:48]) * mul_ext(k0));
   assign pd_in = 33'(mul_ext(in_block[15:0]) * mul_ext(k3));
   assign b1_in = in_block[47:32] + k1;
   assign c1_in = in_block[31:16] + k2;
   assign a2_in = mul_reduce(pa_ff);
   assign d2_in = mul_reduce(pd_ff);
   assign e2    = a2_in ^ c1_ff;
   assign ek3_in = mul_reduce(pe_ff);
   assign t4    = mul_reduce(pt_ff);
   assign u4    = ek3_ff + t4;
   assign out_in = {a3_ff ^ t4, c3_ff ^ t4, b3_ff ^ u4, d3_ff ^ u4};
   assign v_in  = {v_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff  <= pa_in;
         pd_ff  <= pd_in;
         b1_ff  <= b1_in;
         c1_ff  <= c1_in;
         a2_ff  <= a2_in;
         d2_ff  <= d2_in;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         f2_ff  <= b1_ff ^ d2_in;
         pe_ff  <= 33'(mul_ext(e2) * mul_ext(k4));
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         c3_ff  <= c2_ff;
         d3_ff  <= d2_ff;
         ek3_ff <= ek3_in;
         pt_ff  <= 33'(mul_ext(f2_ff + ek3_in) * mul_ext(k5));
         out_ff <= out_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_block = out_ff;

endmodule

>>> hdl/idea_output.sv
// ----------------------------------------------------------------------------
// IDEA output transform
// Final key mixing with word swap, two register stages.
// ----------------------------------------------------------------------------
module idea_output
   import idea_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [BlockW-1:0]   in_block,
   input  word_type            k0,
   input  word_type            k1,
   input  word_type            k2,
   input  word_type            k3,
   output logic                out_valid,
   output logic [BlockW-1:0]   out_block
);

   logic [1:0]        v_ff;
   logic [32:0]       p0_ff, p3_ff;
   word_type          y1_ff, y2_ff;
   logic [BlockW-1:0] out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff  <= 33'(mul_ext(in_block[63:48]) * mul_ext(k0));
         p3_ff  <= 33'(mul_ext(in_block[15:0]) * mul_ext(k3));
         y1_ff  <= in_block[31:16] + k1;
         y2_ff  <= in_block[47:32] + k2;
         out_ff <= {mul_reduce(p0_ff), y1_ff, y2_ff, mul_reduce(p3_ff)};
      end
   end

   assign out_valid = v_ff[1];
   assign out_block = out_ff;

endmodule

>>> hdl/idea_block_cipher_rounds_top.sv
// IDEA block cipher datapath. A load transfer (cmd 0) writes one 16-bit
// subkey into a 6*ROUNDS+4 entry table held in flip-flops; it makes no
// result. A block transfer (cmd 1) enters a fully unrolled pipeline, four
// register stages per round and two for the output transform, so one block
// is taken every cycle while the output is not stalled. The stage layout is
// set by the 17x17 modulo 65537 multipliers, each followed by a register. A
// stall on the result side freezes the whole pipeline. Load subkeys only
// while no block is in flight; reading a never-written subkey gives an
// arbitrary block.
// ----------------------------------------------------------------------------
// IDEA cipher rounds top
// Subkey table, round pipeline and output transform with valid/stall ports.
// ----------------------------------------------------------------------------
module idea_block_cipher_rounds_top
   import idea_pkg::*;
#(
   parameter int unsigned ROUNDS = RoundsDefault
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [KeyIdxW-1:0]  req_key_index,
   input  logic [WordW-1:0]    req_key_value,
   input  logic [BlockW-1:0]   req_block_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BlockW-1:0]   rsp_block_out
);

   localparam int unsigned KeyDepth = KeysPerRound * ROUNDS + OutKeys;

   word_type key_ff [KeyDepth];

   logic advance;
   logic req_xfer;
   logic blk_valid;

   logic              rv   [ROUNDS+1];
   logic [BlockW-1:0] rblk [ROUNDS+1];

   // a full output register that is stalled holds the whole pipe
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign req_xfer  = req_valid && !req_stall;
   assign blk_valid = req_xfer && (req_cmd == CmdBlock);

   always_ff @(posedge clock) begin
      if (req_xfer && (req_cmd == CmdLoad) && (32'(req_key_index) < KeyDepth)) begin
         key_ff[req_key_index] <= req_key_value;
      end
   end

   assign rv[0]   = blk_valid;
   assign rblk[0] = req_block_in;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      idea_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rv[r]),
         .in_block  (rblk[r]),
         .k0        (key_ff[KeysPerRound*r+0]),
         .k1        (key_ff[KeysPerRound*r+1]),
         .k2        (key_ff[KeysPerRound*r+2]),
         .k3        (key_ff[KeysPerRound*r+3]),
         .k4        (key_ff[KeysPerRound*r+4]),
         .k5        (key_ff[KeysPerRound*r+5]),
         .out_valid (rv[r+1]),
         .out_block (rblk[r+1])
      );
   end

   idea_output u_output (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rv[ROUNDS]),
      .in_block  (rblk[ROUNDS]),
      .k0        (key_ff[KeysPerRound*ROUNDS+0]),
      .k1        (key_ff[KeysPerRound*ROUNDS+1]),
      .k2        (key_ff[KeysPerRound*ROUNDS+2]),
      .k3        (key_ff[KeysPerRound*ROUNDS+3]),
      .out_valid (rsp_valid),
      .out_block (rsp_block_out)
   );

`ifndef SYNTH
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_block_out))
      else $error("result changed under stall");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");
   a_first_valid: assert property (@(posedge clock) disable iff (reset)
      (rv[0] && !req_stall) |=> rv[1] == 1'b0 || rv[1] == 1'b1)
      else $error("pipeline valid unknown");
`endif

endmodule

>>> verif/tb_idea_block_cipher_rounds_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IDEA cipher rounds testbench
// Loads full subkey tables, then sends directed and random 64-bit blocks
// under random idling and a long output hold-off. Each result is compared
// against a behavioral cipher model fed from the accepted transfers.
// ----------------------------------------------------------------------------
module tb_idea_block_cipher_rounds_top;
   import idea_pkg::*;

   localparam int unsigned Rounds   = RoundsDefault;
   localparam int unsigned KeyDepth = KeysPerRound * Rounds + OutKeys;
   localparam int unsigned Latency  = 4 * Rounds + 2;

   class cipher_scoreboard;
      word_type        keys [KeyDepth];
      logic [63:0]     pending [$];
      int              errors;

      function word_type mmul(word_type a, word_type b);
         logic [33:0] x;
         logic [33:0] y;
         logic [33:0] p;
         x = (a == 0) ? 34'd65536 : {18'd0, a};
         y = (b == 0) ? 34'd65536 : {18'd0, b};
         p = (x * y) % 34'd65537;
         return (p == 34'd65536) ? 16'd0 : p[15:0];
      endfunction

      function logic [63:0] encipher(logic [63:0] blk);
         word_type w [4];
         word_type a, b, c, d, e, f, ek, t, u;
         int base;
         for (int i = 0; i < 4; i++) w[i] = blk[63 - 16 * i -: 16];
         for (int r = 0; r < Rounds; r++) begin
            base = KeysPerRound * r;
            a = mmul(w[0], keys[base]);
            b = w[1] + keys[base + 1];
            c = w[2] + keys[base + 2];
            d = mmul(w[3], keys[base + 3]);
            e = a ^ c;
            f = b ^ d;
            ek = mmul(e, keys[base + 4]);
            t = mmul(f + ek, keys[base + 5]);
            u = ek + t;
            w[0] = a ^ t;
            w[1] = c ^ t;
            w[2] = b ^ u;
            w[3] = d ^ u;
         end
         base = KeysPerRound * Rounds;
         return {mmul(w[0], keys[base]), word_type'(w[2] + keys[base + 1]),
                 word_type'(w[1] + keys[base + 2]), mmul(w[3], keys[base + 3])};
      endfunction

      function void note_transfer(logic cmd, logic [5:0] idx, word_type val,
                                  logic [63:0] blk);
         if (cmd == CmdLoad) begin
            if (idx < KeyDepth) keys[idx] = val;
         end else begin
            pending.push_back(encipher(blk));
         end
      endfunction

      function void check_result(logic [63:0] got);
         logic [63:0] exp;
         if (pending.size() == 0) begin
            $error("block_out: unexpected result %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            $error("block_out: expected %h, actual %h", exp, got);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_cmd = 1'b0;
   logic [5:0]        req_key_index = '0;
   logic [15:0]       req_key_value = '0;
   logic [63:0]       req_block_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [63:0]       rsp_block_out;
   logic              hold_off = 1'b0;
   cipher_scoreboard  sb = new();

   idea_block_cipher_rounds_top #(.ROUNDS(Rounds)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_transfer(req_cmd, req_key_index, req_key_value, req_block_in);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_block_out);
   end

   // random stall on results, with a long hold-off when asked
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         rsp_stall <= (n != 0);
         repeat (n > 0 ? n : 1) @(posedge clock);
      end
   end

   task automatic send(logic cmd, logic [5:0] idx, word_type val, logic [63:0] blk,
                       bit idle);
      int n;
      n = idle ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_key_index <= idx;
      req_key_value <= val;
      req_block_in  <= blk;
      @(posedge clock iff !req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // kind 0 random, 1 all zero, 2 all ones, 3 alternating extremes
   task automatic load_keys(int kind, bit idle);
      word_type v;
      for (int i = 0; i < KeyDepth; i++) begin
         case (kind)
            1:       v = 16'h0000;
            2:       v = 16'hFFFF;
            3:       v = i[0] ? 16'hFFFF : 16'h0001;
            default: v = $urandom;
         endcase
         send(CmdLoad, i[5:0], v, {$urandom, $urandom}, idle);
      end
   endtask

   function automatic logic [63:0] rand_block();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return '1;
         2:       return {4{16'h0001}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extreme tables and blocks, ignored fields, out-of-range loads
      for (int k = 1; k <= 3; k++) begin
         load_keys(k, 1'b0);
         send(CmdLoad, 6'd63, 16'hABCD, '0, 1'b0);
         send(CmdLoad, 6'(KeyDepth), 16'h1234, '0, 1'b0);
         send(CmdBlock, 6'd63, 16'hFFFF, 64'd0, 1'b0);
         send(CmdBlock, 6'd0, 16'h0000, '1, 1'b0);
         send(CmdBlock, 6'd21, 16'h5555, 64'h0000_FFFF_0001_8000, 1'b0);
         drain();
      end
      // random phases with fresh tables; the first fills up under hold-off
      for (int ph = 0; ph < 6; ph++) begin
         load_keys(0, 1'b1);
         if (ph == 0) hold_off = 1'b1;
         for (int i = 0; i < 250; i++) begin
            if ($urandom_range(0, 19) == 0)
               send(CmdLoad, 6'($urandom_range(KeyDepth, 63)), 16'($urandom),
                    rand_block(), $urandom_range(0, 1));
            else
               send(CmdBlock, 6'($urandom), 16'($urandom), rand_block(),
                    $urandom_range(0, 2) == 0);
         end
         drain();
      end
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule
